@@ sv/bkst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bkst_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_READ_WAIT,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    step_en;
    logic    shift_mode;
    logic    start_shift;
    logic    ins_write;
    logic    dec_count;
    logic    set_status;
    status_t status;
    logic    set_found;
    logic    rd_issue;
    logic    rd_capture;
    logic    load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic hit;
    logic drained;
    logic pos_ok;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/bkst_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bkst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bkst_pkg::dp_stat_t stat,
  output bkst_pkg::dp_cmd_t  cmd
);
  import bkst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_REMOVE: state_nxt = stat.empty ? S_FIN : S_SCAN;
          CMD_READ:   state_nxt = stat.pos_ok ? S_READ : S_FIN;
          default:    state_nxt = S_SCAN;
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_nxt = (stat.cmd == CMD_REMOVE) ? S_SHIFT : S_FIN;
        end else if (stat.drained) begin
          state_nxt = S_FIN;
        end
      end
      S_SHIFT: begin
        if (stat.drained) state_nxt = S_FIN;
      end
      S_READ:      state_nxt = S_READ_WAIT;
      S_READ_WAIT: state_nxt = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    in_stall   = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_DECODE: begin
        if (stat.cmd == CMD_REMOVE && stat.empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_EMPTY;
        end else if (stat.cmd == CMD_READ && !stat.pos_ok) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_RANGE;
        end
      end
      S_SCAN: begin
        cmd.step_en = 1'b1;
        if (stat.hit) begin
          unique case (stat.cmd)
            CMD_INSERT: begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_PRESENT;
            end
            CMD_REMOVE: cmd.start_shift = 1'b1;
            CMD_QUERY:  cmd.set_found   = 1'b1;
            default:    cmd.set_found   = 1'b0;
          endcase
        end else if (stat.drained) begin
          if (stat.cmd == CMD_INSERT) begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.ins_write = 1'b1;
            end
          end else if (stat.cmd == CMD_REMOVE) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_MISSING;
          end
        end
      end
      S_SHIFT: begin
        cmd.step_en    = 1'b1;
        cmd.shift_mode = 1'b1;
        cmd.dec_count  = stat.drained;
      end
      S_READ:      cmd.rd_issue   = 1'b1;
      S_READ_WAIT: cmd.rd_capture = 1'b1;
      S_FIN:       cmd.load_out   = stat.out_free;
      default:     cmd.load_out   = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/bkst_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bkst_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_command,
  input  logic [bkst_pkg::KEY_W-1:0]   in_key,
  input  logic [bkst_pkg::POS_W-1:0]   in_position,
  input  logic                         out_stall,
  input  bkst_pkg::dp_cmd_t            cmd,
  output bkst_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  output logic [bkst_pkg::STAT_W-1:0]  out_status,
  output logic                         out_found,
  output logic [bkst_pkg::KEY_W-1:0]   out_read_key,
  output logic [bkst_pkg::CNT_W-1:0]   out_count
);
  import bkst_pkg::*;

  logic [KEY_W-1:0] mem [CAPACITY];

  cmd_t              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] ridx_r;
  logic              rvalid_r;
  logic [KEY_W-1:0]  rdata_r;

  status_t           res_status_r;
  logic              res_found_r;
  logic [KEY_W-1:0]  res_key_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_found_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              hit;
  logic              more;
  logic              issue;
  logic [POS_W-1:0]  pos_m1;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [KEY_W-1:0]  wdata;

  assign hit    = rvalid_r && (rdata_r == key_r);
  assign more   = (idx_r < count_r);
  // no new read once the key matched while searching
  assign issue  = cmd.step_en && more && (cmd.shift_mode || !hit);
  assign pos_m1 = pos_r - POS_W'(1);
  assign raddr  = cmd.rd_issue ? pos_m1[ADDR_W-1:0] : idx_r[ADDR_W-1:0];

  // shift: entry read last cycle moves down one place
  assign we    = cmd.ins_write || (cmd.shift_mode && rvalid_r);
  assign waddr = cmd.ins_write ? count_r[ADDR_W-1:0] : ridx_r - ADDR_W'(1);
  assign wdata = cmd.ins_write ? key_r : rdata_r;

  always_comb begin
    stat.cmd      = cmd_r;
    stat.empty    = (count_r == '0);
    stat.full     = (count_r == CNT_W'(CAPACITY));
    stat.hit      = hit;
    stat.drained  = !rvalid_r && !more;
    stat.pos_ok   = (pos_r != '0) && (pos_r <= count_r);
    stat.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.accept) begin
      idx_nxt = '0;
    end else if (cmd.start_shift) begin
      idx_nxt = CNT_W'(ridx_r) + CNT_W'(1);
    end else if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_write) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.dec_count) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rvalid_r <= issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (issue) ridx_r <= idx_r[ADDR_W-1:0];
    if (cmd.accept) begin
      cmd_r        <= cmd_t'(in_command);
      key_r        <= in_key;
      pos_r        <= in_position;
      res_status_r <= ST_OK;
      res_found_r  <= 1'b0;
      res_key_r    <= '0;
    end else begin
      if (cmd.set_status) res_status_r <= cmd.status;
      if (cmd.set_found)  res_found_r  <= 1'b1;
      if (cmd.rd_capture) res_key_r    <= rdata_r;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_key_r    <= res_key_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_read_key = out_key_r;
  assign out_count    = out_count_r;

endmodule
`default_nettype wire

@@ sv/bounded_key_set_table.sv @@
// insert and query search the entries; remove also compacts them after a hit; read fetches
// the entry at its position; remove on an empty table or read out of range ends at decode
// throughput: one command at a time, the next accepted in the cycle after the result is loaded,
// later while it stalls; set by the entry sweep, one entry per cycle for search and for the
// compacting shift, using the read and the write port of the entry memory together
// reset: synchronous active-low rst_n empties the table (count zero), no sweep
`timescale 1ns / 1ps
`default_nettype none
module bounded_key_set_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [bkst_pkg::KEY_W-1:0]   in_key,
  input  logic [bkst_pkg::POS_W-1:0]   in_position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bkst_pkg::STAT_W-1:0]  out_status,
  output logic                         out_found,
  output logic [bkst_pkg::KEY_W-1:0]   out_read_key,
  output logic [bkst_pkg::CNT_W-1:0]   out_count
);
  import bkst_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bkst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bkst_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_command   (in_command),
    .in_key       (in_key),
    .in_position  (in_position),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_read_key (out_read_key),
    .out_count    (out_count)
  );

endmodule
`default_nettype wire

@@ sv/bkst_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bkst_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   in_command,
  input logic [bkst_pkg::KEY_W-1:0]   in_key,
  input logic [bkst_pkg::POS_W-1:0]   in_position,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bkst_pkg::STAT_W-1:0]  out_status,
  input logic                         out_found,
  input logic [bkst_pkg::KEY_W-1:0]   out_read_key,
  input logic [bkst_pkg::CNT_W-1:0]   out_count
);
  import bkst_pkg::*;

  // count never exceeds the table capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // a member reported only with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found with failing status");

  // a failed command never returns a key
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_key == '0)
    else $error("key returned with failing status");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_RANGE)
    else $error("undefined status code");

  // a held transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind bounded_key_set_table bkst_chk u_bkst_chk (.*);
`default_nettype wire
